// ===== rtl/cnms_pkg.sv =====
// shared types, codes and helpers for the canny non-max suppression block
// no dependencies
package cnms_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 4096;

  localparam int WIDTH_REG_W  = 12;
  localparam int HEIGHT_REG_W = 13;
  localparam int SUM_W        = 10;
  localparam int DIR_W        = 3;
  localparam int CFG_ADDR_W   = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // gradient direction codes
  localparam logic [DIR_W-1:0] DIR_0   = 3'd0;
  localparam logic [DIR_W-1:0] DIR_45  = 3'd1;
  localparam logic [DIR_W-1:0] DIR_90  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_135 = 3'd3;

  typedef logic [SUM_W-1:0] sum_t;

  // one column of line memory: two rows of sums and the direction of the row above
  typedef struct packed {
    sum_t             sum_up2;
    sum_t             sum_up1;
    logic [DIR_W-1:0] dir_up1;
  } line_entry_t;

  // floor(x / 3) for x up to 765, by reciprocal 683 / 2048
  function automatic logic [7:0] div3(input sum_t x);
    logic [19:0] prod;
    prod = 20'(x) * 20'd683;
    return prod[18:11];
  endfunction

endpackage

// ===== rtl/canny_non_max_suppression_3x3.sv =====
// canny non-maximum suppression over a 3x3 window of channel-sum intensities
// depends on cnms_pkg (types, codes, divide-by-three helper)

// One pixel per clock while the output is not stalled. Each pixel's r+g+b sum goes
// to a simple dual-port line memory (one read at acceptance, one write when the pixel
// leaves the input stage) that holds, per column, the sums of the two rows above and
// the direction of the row above. A pixel is accepted into an input stage, the memory
// read lands alongside it, and one short stage of compare and divide-by-three fills
// the output register. Inside the stream a result belongs to the centre one
// row and one pixel behind the pixel just taken, so the first result of a frame
// appears with pixel (1,1), and a frame gives (height-1)*(width-1) results; out_tlast
// marks the last of them. Border centres come out as zero. A register write restarts
// the frame position at pixel (0,0) and keeps the line memory; no clearing pass is
// needed since every stored value that reaches a non-border centre was written
// earlier in the same frame. Width and height, taken from the low 12 and 13 bits of the
// written word, are clamped to [3, MAX_WIDTH] and [3, MAX_HEIGHT].
module canny_non_max_suppression_3x3 #(
  parameter int MAX_WIDTH  = cnms_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cnms_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // pixel requests
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [31:0]                     in_tdata,   // red[7:0] green[15:8] blue[23:16] direction[26:24]
  // result requests
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [7:0]                      out_tdata,  // gray_value[7:0]
  output logic                            out_tlast,  // frame_last
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cnms_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import cnms_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CCMPW = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;
  localparam int RCMPW = (RW > HEIGHT_REG_W) ? RW : HEIGHT_REG_W;

  // configuration registers
  logic [WIDTH_REG_W-1:0]  frame_width_r;
  logic [HEIGHT_REG_W-1:0] frame_height_r;
  logic                    cfg_wr;
  logic [WIDTH_REG_W-1:0]  wval;
  logic [HEIGHT_REG_W-1:0] hval;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign wval       = cfg_pwdata[WIDTH_REG_W-1:0];
  assign hval       = cfg_pwdata[HEIGHT_REG_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_FRAME_WIDTH: begin
          if (wval < 12'd3) begin
            frame_width_r <= 12'd3;
          end else if (32'(wval) > 32'(MAX_WIDTH)) begin
            frame_width_r <= WIDTH_REG_W'(MAX_WIDTH);
          end else begin
            frame_width_r <= wval;
          end
        end
        REG_FRAME_HEIGHT: begin
          if (hval < 13'd3) begin
            frame_height_r <= 13'd3;
          end else if (32'(hval) > 32'(MAX_HEIGHT)) begin
            frame_height_r <= HEIGHT_REG_W'(MAX_HEIGHT);
          end else begin
            frame_height_r <= hval;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_FRAME_WIDTH:  cfg_prdata = 32'(frame_width_r);
      REG_FRAME_HEIGHT: cfg_prdata = 32'(frame_height_r);
      default:          cfg_prdata = 32'd0;
    endcase
  end

  // raster position of the next pixel
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          col_last;
  logic          row_last;
  logic          in_fire;

  assign col_last = CCMPW'(col_r) >= CCMPW'(frame_width_r - 12'd1);
  assign row_last = RCMPW'(row_r) >= RCMPW'(frame_height_r - 13'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : row_r + RW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // input stage
  logic             s1_valid_r;
  sum_t             s1_sum_r;
  logic [DIR_W-1:0] s1_dir_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_emit_r;   // centre lies inside the emitted region
  logic             s1_inner_r;  // centre is off the top and left border
  logic             s1_flast_r;
  logic             s1_fire;
  sum_t             in_sum;

  assign in_sum = SUM_W'(in_tdata[7:0]) + SUM_W'(in_tdata[15:8]) + SUM_W'(in_tdata[23:16]);
  assign s1_fire   = s1_valid_r & (~out_tvalid | out_tready);
  assign in_tready = ~s1_valid_r | s1_fire;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sum_r   <= in_sum;
      s1_dir_r   <= in_tdata[26:24];
      s1_col_r   <= col_r;
      s1_emit_r  <= (row_r != '0) && (col_r != '0);
      s1_inner_r <= (RCMPW'(row_r) >= RCMPW'(2)) && (CCMPW'(col_r) >= CCMPW'(2));
      s1_flast_r <= row_last & col_last;
    end
  end

  // line memory: read at acceptance, written back once the pixel leaves the input stage
  line_entry_t line_mem [MAX_WIDTH];
  line_entry_t rd_q_r;
  line_entry_t wr_entry;

  assign wr_entry = '{sum_up2: rd_q_r.sum_up1, sum_up1: s1_sum_r, dir_up1: s1_dir_r};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_q_r <= line_mem[col_r];
    end
    if (s1_fire) begin
      line_mem[s1_col_r] <= wr_entry;
    end
  end

  // 3x3 window, [row: two above, above, current][column: oldest .. newest]
  sum_t             win_r   [3][3];
  sum_t             win_nxt [3][3];
  logic [DIR_W-1:0] dwin_r  [3];
  logic [DIR_W-1:0] dwin_nxt[3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_nxt[k][0] = win_r[k][1];
      win_nxt[k][1] = win_r[k][2];
    end
    win_nxt[0][2] = rd_q_r.sum_up2;
    win_nxt[1][2] = rd_q_r.sum_up1;
    win_nxt[2][2] = s1_sum_r;
    dwin_nxt[0]   = dwin_r[1];
    dwin_nxt[1]   = dwin_r[2];
    dwin_nxt[2]   = rd_q_r.dir_up1;
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      win_r  <= win_nxt;
      dwin_r <= dwin_nxt;
    end
  end

  // suppression decision on the updated window
  sum_t       ctr;
  sum_t       nb_a;
  sum_t       nb_b;
  logic       keep;
  logic [7:0] gray;

  always_comb begin
    ctr  = win_nxt[1][1];
    nb_a = '0;
    nb_b = '0;
    keep = 1'b1;
    case (dwin_nxt[1])
      DIR_0: begin
        nb_a = win_nxt[1][0];
        nb_b = win_nxt[1][2];
        keep = (ctr >= nb_a) && (ctr >= nb_b);
      end
      DIR_45: begin
        nb_a = win_nxt[0][2];
        nb_b = win_nxt[2][0];
        keep = (ctr >= nb_a) && (ctr >= nb_b);
      end
      DIR_90: begin
        nb_a = win_nxt[0][1];
        nb_b = win_nxt[2][1];
        keep = (ctr >= nb_a) && (ctr >= nb_b);
      end
      DIR_135: begin
        nb_a = win_nxt[0][0];
        nb_b = win_nxt[2][2];
        keep = (ctr >= nb_a) && (ctr >= nb_b);
      end
      default: keep = 1'b1;  // unknown direction passes through
    endcase
    gray = (s1_inner_r && keep) ? div3(ctr) : 8'd0;
  end

  // output register
  logic       out_valid_r;
  logic [7:0] out_gray_r;
  logic       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= s1_emit_r;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit_r) begin
      out_gray_r <= gray;
      out_last_r <= s1_flast_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_gray_r;
  assign out_tlast  = out_last_r;

endmodule
